>>> hw/rtl/cws_pkg.sv
// ----------------------------------------------------------------------------
// cws_pkg - shared types and constants of the congestion window sender
// Action and result kind codes, register map, sequencer states and the
// field layout of the streams.
// ----------------------------------------------------------------------------
package cws_pkg;

	// input actions, carried in s_tuser
	typedef enum logic [1:0] {
		ACT_SEND  = 2'd0,
		ACT_ACK   = 2'd1,
		ACT_END   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// result kinds, carried in m_tuser
	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// register indexes, byte address is 4 * index
	typedef enum logic [1:0] {
		REG_SEGS_PER_FRAME = 2'd0,
		REG_LAST_SEG_LEN   = 2'd1,
		REG_INIT_THRESHOLD = 2'd2,
		REG_UNUSED         = 2'd3
	} reg_idx_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT,
		ST_STATUS
	} state_t;

	// field widths
	localparam int SEQ_W   = 32;
	localparam int IDX_W   = 12;
	localparam int LEN_W   = 13;
	localparam int FRM_W   = 13;
	localparam int WIN_W   = 6;
	localparam int DATA_W  = 80;

	// burst limit and register reset values
	localparam int          RESULT_CAP      = 32;
	localparam logic [12:0] SEGS_RESET      = 13'd1;
	localparam logic [12:0] LAST_LEN_RESET  = 13'd4096;
	localparam logic [5:0]  INIT_THR_RESET  = 6'd16;

	// bit positions in m_tdata
	localparam int POS_SEQ   = 0;
	localparam int POS_IDX   = 32;
	localparam int POS_LEN   = 44;
	localparam int POS_BE    = 57;
	localparam int POS_FE    = 58;
	localparam int POS_WIN   = 59;
	localparam int POS_THR   = 65;
	localparam int POS_TO    = 71;
	localparam int POS_FD    = 72;

endpackage

>>> hw/rtl/congestion_window_sender.sv
// ----------------------------------------------------------------------------
// congestion_window_sender - window controlled segment descriptor source
// Slow-start / congestion-avoidance window with timeout fallback.
// ----------------------------------------------------------------------------
// Input words on s_* carry an action in s_tuser (send round, ack, round end)
// and an ack number in s_tdata. A send round emits up to one window (at most
// RESULT_CAP) of segment descriptors on m_*, one per cycle while m_tready is high,
// the last one marked with tlast. A round end emits one status word. An ack
// gives no output word.
// A round end registers the status word in a status state once the output
// register is free. A send round runs the frame index through a single
// restoring remainder unit, one quotient bit per cycle, then emits the
// descriptors. A round after a frame end that has not yet been closed by a
// round end sends nothing.
// A single output register parts both sides; when the receiver stalls the
// sequencer waits and s_tready stays low until the round is done.
// Reset puts the window at 1, threshold and registers at their defaults,
// and the next sequence number at 1. Registers sit on an APB port; the user
// must write them only while the block is idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module congestion_window_sender #(
	parameter int MAX_WINDOW         = 32,
	parameter int SEGMENT_BYTES      = 4096,
	parameter int MAX_FRAME_SEGMENTS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // ack_number[31:0]
	input  logic [1:0]  s_tuser,  // action[1:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// seq_number[31:0], segment_index[43:32], length[56:44], burst_end[57],
	// frame_end[58], window_size[64:59], threshold_now[70:65], timed_out[71],
	// frame_done[72], zero[79:73]
	output logic [79:0] m_tdata,
	output logic [0:0]  m_tuser,  // kind[0]
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic [6:0] WIN_CAP = (MAX_WINDOW > 63) ? 7'd63 : 7'(MAX_WINDOW);
	localparam logic [12:0] SEG_LEN = 13'(SEGMENT_BYTES);
	localparam logic [5:0] THR_RESET = ({1'b0, cws_pkg::INIT_THR_RESET} > WIN_CAP) ?
		WIN_CAP[5:0] : cws_pkg::INIT_THR_RESET;
	localparam logic [5:0] BURST_CAP = 6'(cws_pkg::RESULT_CAP);

	// threshold clamp to 1..WIN_CAP (MAX_WINDOW, at most 63)
	function automatic logic [5:0] clamp_thr(input logic [6:0] t);
		logic [6:0] r;
		r = t;
		if (r == 7'd0) r = 7'd1;
		if (r > WIN_CAP) r = WIN_CAP;
		return r[5:0];
	endfunction

	// configuration registers
	logic [12:0] segs_cfg_q;
	logic [12:0] last_len_cfg_q;
	logic [5:0]  init_thr_cfg_q;

	// protocol state
	logic [31:0] next_seq_q;
	logic [31:0] latest_ack_q;
	logic [5:0]  window_q;
	logic [5:0]  thr_q;
	logic [5:0]  sent_q;
	logic [5:0]  acks_q;
	logic        fe_sent_q;

	// sequencer
	cws_pkg::state_t state_q, state_d;
	logic [4:0]  bit_cnt_q;
	logic [31:0] dividend_q;
	logic [12:0] rem_q;
	logic [12:0] frames_q;
	logic [5:0]  count_q;
	logic [5:0]  n_q;
	logic        to_q;
	logic        fd_q;

	// output register
	logic        m_valid_q;
	logic [79:0] m_data_q;
	logic        m_kind_q;
	logic        m_last_q;

	logic        cfg_wr;
	logic        s_acc;
	logic        out_free;
	logic        emit_fire;
	logic        stat_fire;
	logic        div_done;
	cws_pkg::action_t act;
	logic [12:0] frames_eff;
	logic [12:0] last_len_eff;
	logic [13:0] rem_shift;
	logic        rem_ge;
	logic [12:0] rem_next;
	logic        seg_fe;
	logic        seg_be;
	logic [12:0] seg_len;
	logic        round_to;
	logic [6:0]  win_grow;
	logic [6:0]  win_sat;

	assign pready   = 1'b1;
	assign cfg_wr   = psel & penable & pwrite;
	assign s_acc    = s_tvalid & s_tready;
	assign act      = cws_pkg::action_t'(s_tuser);
	assign out_free = ~m_valid_q | m_tready;

	// register readback
	always_comb begin
		case (cws_pkg::reg_idx_t'(paddr[3:2]))
			cws_pkg::REG_SEGS_PER_FRAME: prdata = {19'd0, segs_cfg_q};
			cws_pkg::REG_LAST_SEG_LEN:   prdata = {19'd0, last_len_cfg_q};
			cws_pkg::REG_INIT_THRESHOLD: prdata = {26'd0, init_thr_cfg_q};
			default:                     prdata = 32'd0;
		endcase
	end

	// effective frame size and short segment length
	always_comb begin
		frames_eff = segs_cfg_q;
		if (segs_cfg_q == 13'd0) frames_eff = 13'd1;
		else if (32'(segs_cfg_q) > MAX_FRAME_SEGMENTS) frames_eff = 13'(MAX_FRAME_SEGMENTS);
		last_len_eff = (32'(last_len_cfg_q) > SEGMENT_BYTES) ? SEG_LEN : last_len_cfg_q;
	end

	// single remainder unit, one bit per cycle
	always_comb begin
		rem_shift = {rem_q, dividend_q[31]};
		rem_ge    = rem_shift >= {1'b0, frames_q};
		rem_next  = rem_ge ? 13'(rem_shift - {1'b0, frames_q}) : rem_shift[12:0];
	end

	// descriptor of the current segment, rem_q holds its index
	always_comb begin
		seg_fe  = rem_q == (frames_q - 13'd1);
		seg_be  = seg_fe | (n_q == (count_q - 6'd1));
		seg_len = seg_fe ? last_len_eff : SEG_LEN;
	end

	// round end outcome
	always_comb begin
		round_to = acks_q < sent_q;
		win_grow = (window_q < thr_q) ? {window_q, 1'b0} : 7'({1'b0, window_q} + 7'd1);
		win_sat  = (win_grow > WIN_CAP) ? WIN_CAP : win_grow;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cws_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (act == cws_pkg::ACT_SEND && !fe_sent_q) state_d = cws_pkg::ST_DIV;
					else if (act == cws_pkg::ACT_END) state_d = cws_pkg::ST_STATUS;
				end
			end
			cws_pkg::ST_DIV: begin
				if (bit_cnt_q == 5'd0) state_d = cws_pkg::ST_EMIT;
			end
			cws_pkg::ST_EMIT: begin
				if (out_free && seg_be) state_d = cws_pkg::ST_IDLE;
			end
			cws_pkg::ST_STATUS: begin
				if (out_free) state_d = cws_pkg::ST_IDLE;
			end
			default: state_d = cws_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		emit_fire = 1'b0;
		stat_fire = 1'b0;
		div_done  = 1'b0;
		case (state_q)
			cws_pkg::ST_IDLE:   s_tready  = 1'b1;
			cws_pkg::ST_DIV:    div_done  = bit_cnt_q == 5'd0;
			cws_pkg::ST_EMIT:   emit_fire = out_free;
			cws_pkg::ST_STATUS: stat_fire = out_free;
			default:            s_tready  = 1'b0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cws_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration and protocol state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segs_cfg_q     <= cws_pkg::SEGS_RESET;
			last_len_cfg_q <= cws_pkg::LAST_LEN_RESET;
			init_thr_cfg_q <= cws_pkg::INIT_THR_RESET;
			next_seq_q     <= 32'd1;
			latest_ack_q   <= 32'd0;
			window_q       <= 6'd1;
			thr_q          <= THR_RESET;
			sent_q         <= 6'd0;
			acks_q         <= 6'd0;
			fe_sent_q      <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (cws_pkg::reg_idx_t'(paddr[3:2]))
					cws_pkg::REG_SEGS_PER_FRAME: segs_cfg_q <= pwdata[12:0];
					cws_pkg::REG_LAST_SEG_LEN:   last_len_cfg_q <= pwdata[12:0];
					cws_pkg::REG_INIT_THRESHOLD: begin
						init_thr_cfg_q <= pwdata[5:0];
						thr_q          <= clamp_thr({1'b0, pwdata[5:0]});
					end
					default: ;
				endcase
			end
			if (s_acc) begin
				case (act)
					cws_pkg::ACT_SEND: begin
						acks_q <= 6'd0;
						if (fe_sent_q) sent_q <= 6'd0;
					end
					cws_pkg::ACT_ACK: begin
						if (acks_q < sent_q) begin
							latest_ack_q <= s_tdata;
							acks_q       <= acks_q + 6'd1;
						end
					end
					cws_pkg::ACT_END: begin
						if (round_to) begin
							thr_q      <= clamp_thr({2'b0, window_q[5:1]});
							window_q   <= 6'd1;
							next_seq_q <= latest_ack_q + 32'd1;
						end else begin
							window_q <= win_sat[5:0];
						end
						fe_sent_q <= 1'b0;
						sent_q    <= 6'd0;
						acks_q    <= 6'd0;
					end
					default: ;
				endcase
			end
			if (emit_fire) begin
				next_seq_q <= next_seq_q + 32'd1;
				if (seg_fe) fe_sent_q <= 1'b1;
				if (seg_be) sent_q <= n_q + 6'd1;
			end
		end
	end

	// round working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= 5'd0;
			n_q       <= 6'd0;
			to_q      <= 1'b0;
			fd_q      <= 1'b0;
		end else begin
			if (s_acc && act == cws_pkg::ACT_SEND) begin
				bit_cnt_q <= 5'd31;
				n_q       <= 6'd0;
			end else if (state_q == cws_pkg::ST_DIV && !div_done) begin
				bit_cnt_q <= bit_cnt_q - 5'd1;
			end
			if (emit_fire) n_q <= n_q + 6'd1;
			if (s_acc && act == cws_pkg::ACT_END) begin
				to_q <= round_to;
				fd_q <= ~round_to & fe_sent_q;
			end
		end
	end

	// divider datapath, rem_q then walks the frame index
	// (seq - 1) wraps from all ones to zero after sequence zero, so the index restarts
	always_ff @(posedge clk) begin
		if (s_acc && act == cws_pkg::ACT_SEND) begin
			dividend_q <= next_seq_q - 32'd1;
			rem_q      <= 13'd0;
			frames_q   <= frames_eff;
			count_q    <= (window_q > BURST_CAP) ? BURST_CAP : window_q;
		end else if (state_q == cws_pkg::ST_DIV) begin
			dividend_q <= {dividend_q[30:0], 1'b0};
			rem_q      <= rem_next;
		end else if (emit_fire) begin
			rem_q <= (seg_fe || next_seq_q == 32'd0) ? 13'd0 : rem_q + 13'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit_fire || stat_fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			m_kind_q <= cws_pkg::KIND_SEGMENT;
			m_last_q <= seg_be;
			m_data_q <= {7'd0, 1'b0, 1'b0, thr_q, window_q, seg_fe, seg_be, seg_len,
				rem_q[11:0], next_seq_q};
		end else if (stat_fire) begin
			m_kind_q <= cws_pkg::KIND_STATUS;
			m_last_q <= 1'b1;
			m_data_q <= {7'd0, fd_q, to_q, thr_q, window_q, 1'b0, 1'b0, 13'd0, 12'd0,
				next_seq_q};
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_kind_q;
	assign m_tlast    = m_last_q;

endmodule

>>> hw/rtl/cws_checker.sv
// ----------------------------------------------------------------------------
// cws_checker - port level checks of the congestion window sender
// Watches the output stream and the window fields it reports.
// ----------------------------------------------------------------------------
module cws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled word stays and holds its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output word changed while stalled");

	// a status word always closes its input
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == cws_pkg::KIND_STATUS |-> m_tlast)
		else $error("status word without tlast");

	// frame end closes the burst
	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == cws_pkg::KIND_SEGMENT && m_tdata[cws_pkg::POS_FE]
			|-> m_tdata[cws_pkg::POS_BE] && m_tlast)
		else $error("frame end segment does not end the burst");

	// descriptors carry no round outcome, tlast follows burst_end
	a_segment_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] == cws_pkg::KIND_SEGMENT
			|-> !m_tdata[cws_pkg::POS_TO] && !m_tdata[cws_pkg::POS_FD]
			&& (m_tlast == m_tdata[cws_pkg::POS_BE]))
		else $error("segment word with status flags");

	// window and threshold never read zero
	a_window_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[cws_pkg::POS_WIN +: 6] != 6'd0
			&& m_tdata[cws_pkg::POS_THR +: 6] != 6'd0)
		else $error("zero window or threshold reported");

endmodule

bind congestion_window_sender cws_checker u_cws_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
